/* sv/masked_byte_pattern_search_macros.svh */
// Assertion macros used by the scanner's top RTL file.
`ifndef MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH
`define MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MBPS_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MBPS_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

/* sv/mbps_pkg.sv */
// Shared types and constants of the masked byte pattern scanner.
`default_nettype none

package mbps_pkg;

  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 48;
  localparam int REG_BYTES   = 16;
  localparam int IDX_W       = 4;
  localparam int LEN_W       = 5;
  localparam int MASK_W      = 16;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_CARE_MASK      = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_BASE_ADDRESS   = 3'd4
  } cfg_reg_t;

  // Compare setup handed to one window cell.
  typedef struct packed {
    logic [BYTE_W-1:0] expect_byte;
    logic              care;
    logic              used;
  } cell_cmp_t;

endpackage

`default_nettype wire

/* sv/mbps_channels.sv */
// Request channels of the scanner: input bytes and scan results.
`default_nettype none

interface mbps_byte_if import mbps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_result_if import mbps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [ADDR_W-1:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink   (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

/* sv/masked_byte_pattern_search.sv */
// Masked byte pattern scanner: takes one byte per cycle and reports the first match of a
// region. A byte enters a row of window cells on acceptance and all cells compare against
// the pattern in the next cycle; the result then sits in an output register until taken.
// One byte is accepted every cycle as long as the result side takes results; the
// comparison stage stalls only when it holds a result and the output register is full
// and not being taken. Each region gives exactly one result: found with its address, or
// not found on the region's last byte.
`default_nettype none
`include "masked_byte_pattern_search_macros.svh"

module masked_byte_pattern_search import mbps_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int COUNT_WIDTH       = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  mbps_byte_if.sink              bytes,
  mbps_result_if.source          results,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NCELL = (MAX_PATTERN_BYTES < REG_BYTES) ? MAX_PATTERN_BYTES : REG_BYTES;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Configuration registers
  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [MASK_W-1:0]     care_mask;
  logic [LEN_W-1:0]      pattern_length;
  logic [ADDR_W-1:0]     base_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '1;
      pattern_length <= LEN_W'(1);
      base_address   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_CARE_MASK:      care_mask      <= cfg_data[MASK_W-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_BASE_ADDRESS:   base_address   <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0]  eff_len;
  logic [BYTE_W-1:0] pat [REG_BYTES];

  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length > LEN_W'(NCELL)) begin
      eff_len = LEN_W'(NCELL);
    end else begin
      eff_len = pattern_length;
    end
  end

  always_comb begin
    for (int k = 0; k < REG_BYTES; k++) begin
      if (k < REG_BYTES / 2) begin
        pat[k] = pattern_low[BYTE_W*k +: BYTE_W];
      end else begin
        pat[k] = pattern_high[BYTE_W*(k - REG_BYTES/2) +: BYTE_W];
      end
    end
  end

  // Accept stage: count bytes, prepare offset and length check
  logic                   acc;
  logic                   s1_adv;
  logic                   s1_valid;
  logic                   s1_last;
  logic                   s1_long;
  logic [COUNT_WIDTH-1:0] s1_offset;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   region_start;
  logic                   match_reported;

  assign acc         = bytes.valid && bytes.ready;
  assign bytes.ready = !s1_valid || s1_adv;

  always_comb begin
    if (region_start) begin
      count_next = COUNT_WIDTH'(1);
    end else if (count == COUNT_MAX) begin
      count_next = count;
    end else begin
      count_next = count + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      region_start <= 1'b1;
      count        <= '0;
    end else begin
      if (acc) begin
        s1_valid     <= 1'b1;
        region_start <= bytes.last_byte;
        count        <= count_next;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_last   <= bytes.last_byte;
      s1_long   <= count_next >= COUNT_WIDTH'(eff_len);
      s1_offset <= count_next - COUNT_WIDTH'(eff_len);
    end
  end

  // Row of window cells; cell 0 holds the newest byte
  logic [BYTE_W-1:0] cell_byte  [NCELL];
  logic [NCELL-1:0]  cell_match;
  cell_cmp_t         cell_cmp   [NCELL];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [LEN_W-1:0] pos;
    logic [IDX_W-1:0] k;

    // Cell i lines up with pattern byte eff_len-1-i
    assign pos = eff_len - LEN_W'(1) - LEN_W'(i);
    assign k   = pos[IDX_W-1:0];

    assign cell_cmp[i].used        = LEN_W'(i) < eff_len;
    assign cell_cmp[i].care        = care_mask[k];
    assign cell_cmp[i].expect_byte = pat[k];

    if (i == 0) begin : g_head
      mbps_cell u_cell (
        .clk      (clk),
        .shift_en (acc),
        .byte_in  (bytes.data_byte),
        .cmp      (cell_cmp[i]),
        .byte_out (cell_byte[i]),
        .match    (cell_match[i])
      );
    end else begin : g_body
      mbps_cell u_cell (
        .clk      (clk),
        .shift_en (acc),
        .byte_in  (cell_byte[i-1]),
        .cmp      (cell_cmp[i]),
        .byte_out (cell_byte[i]),
        .match    (cell_match[i])
      );
    end
  end

  // Compare stage
  logic hit;
  logic emit;

  assign hit    = s1_long && !match_reported && (&cell_match);
  assign emit   = s1_valid && (hit || (s1_last && !match_reported));
  assign s1_adv = s1_valid && (!emit || !results.valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_reported <= 1'b0;
      results.valid  <= 1'b0;
    end else begin
      if (s1_adv) begin
        if (s1_last) begin
          match_reported <= 1'b0;
        end else if (hit) begin
          match_reported <= 1'b1;
        end
      end
      if (s1_adv && emit) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      results.found         <= hit;
      results.match_address <= hit ? base_address + ADDR_W'(s1_offset) : '0;
    end
  end

  `MBPS_ASSERT_NOW(a_not_found_zero, results.valid && !results.found, results.match_address == '0, "not-found result carries a nonzero address")
  `MBPS_ASSERT_NEXT(a_region_first_count, acc && region_start, count == COUNT_WIDTH'(1), "first byte of a region not counted as one")
  `MBPS_ASSERT_NEXT(a_region_end_clears, s1_adv && s1_last, !match_reported, "match flag survives the end of a region")
  `MBPS_ASSERT_NOW(a_one_found_per_region, emit && hit, !match_reported, "second match reported in one region")

endmodule

`default_nettype wire

/* sv/mbps_cell.sv */
// One window cell: holds a byte, passes it on, and checks it against its pattern byte.
`default_nettype none

module mbps_cell import mbps_pkg::*; (
  input  logic              clk,
  input  logic              shift_en,
  input  logic [BYTE_W-1:0] byte_in,
  input  cell_cmp_t         cmp,
  output logic [BYTE_W-1:0] byte_out,
  output logic              match
);

  logic [BYTE_W-1:0] window_byte;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      window_byte <= byte_in;
    end
  end

  assign byte_out = window_byte;
  // Cells past the pattern length and wildcard bytes always agree.
  assign match = !cmp.used || !cmp.care || (window_byte == cmp.expect_byte);

endmodule

`default_nettype wire
